FILE: src/tlsf_pkg.sv
`default_nettype none

package tlsf_pkg;

  localparam int FIRST_DEPTH_DEF  = 6;
  localparam int SECOND_DEPTH_DEF = 3;

  localparam int ACCT_W = 31;
  localparam int AMT_W  = 32;
  localparam int REC_W  = ACCT_W + 1 + AMT_W;

  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_POP1  = 3'd1;
  localparam logic [2:0] OP_POP2  = 3'd2;
  localparam logic [2:0] OP_LIST1 = 3'd3;
  localparam logic [2:0] OP_LIST2 = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic load_rec;
    logic spill_move;
    logic enq_push;
    logic pop_first;
    logic pop_second;
    logic idx_clr;
    logic idx_inc;
    logic look_ahead;
    logic sel_second;
    logic emit_enq;
    logic emit_rec;
    logic emit_empty;
    logic last;
  } tlsf_cmd_t;

  typedef struct packed {
    logic first_full;
    logic second_full;
    logic spill_more;
    logic first_empty;
    logic second_empty;
    logic first_at_last;
    logic second_at_last;
  } tlsf_stat_t;

endpackage

`default_nettype wire

FILE: src/tlsf_ram.sv
`default_nettype none

module tlsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/tlsf_dp.sv
`default_nettype none

module tlsf_dp #(
  parameter int FIRST_DEPTH  = tlsf_pkg::FIRST_DEPTH_DEF,
  parameter int SECOND_DEPTH = tlsf_pkg::SECOND_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tlsf_pkg::tlsf_cmd_t       cmd,
  output tlsf_pkg::tlsf_stat_t           stat,
  input  wire logic [30:0]               account,
  input  wire logic                      kind,
  input  wire logic [31:0]               amount_cents,
  output logic                           valid,
  output logic [1:0]                     status,
  output logic [30:0]                    rec_account,
  output logic                           rec_kind,
  output logic [31:0]                    rec_amount,
  output logic [1:0]                     moved_count,
  output logic                           last
);

  import tlsf_pkg::*;

  localparam int PW1 = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int PW2 = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int CW1 = $clog2(FIRST_DEPTH + 1);
  localparam int CW2 = $clog2(SECOND_DEPTH + 1);
  localparam int IW  = (CW1 > CW2) ? CW1 : CW2;

  logic [PW1-1:0]   first_head;
  logic [CW1-1:0]   first_count;
  logic [PW2-1:0]   second_head;
  logic [CW2-1:0]   second_count;
  logic [IW-1:0]    idx;
  logic [1:0]       moved;
  logic [REC_W-1:0] rec;

  logic [CW1:0]     ofs1, rsum1, tsum1;
  logic [CW2:0]     ofs2, rsum2, tsum2;
  logic [PW1-1:0]   raddr1, tail1, head1_inc;
  logic [PW2-1:0]   raddr2, tail2, head2_inc;
  logic [REC_W-1:0] rdata1, rdata2, rdata_sel;
  logic             we1;

  always_comb begin
    ofs1 = '0;
    ofs2 = '0;
    if (cmd.sel_second) begin
      ofs2 = (CW2 + 1)'(idx) + (CW2 + 1)'(cmd.look_ahead);
    end else begin
      ofs1 = (CW1 + 1)'(idx) + (CW1 + 1)'(cmd.look_ahead);
    end
    rsum1 = (CW1 + 1)'(first_head) + ofs1;
    rsum2 = (CW2 + 1)'(second_head) + ofs2;
    tsum1 = (CW1 + 1)'(first_head) + (CW1 + 1)'(first_count);
    tsum2 = (CW2 + 1)'(second_head) + (CW2 + 1)'(second_count);
    raddr1 = (rsum1 >= (CW1 + 1)'(FIRST_DEPTH)) ?
             PW1'(rsum1 - (CW1 + 1)'(FIRST_DEPTH)) : PW1'(rsum1);
    raddr2 = (rsum2 >= (CW2 + 1)'(SECOND_DEPTH)) ?
             PW2'(rsum2 - (CW2 + 1)'(SECOND_DEPTH)) : PW2'(rsum2);
    tail1  = (tsum1 >= (CW1 + 1)'(FIRST_DEPTH)) ?
             PW1'(tsum1 - (CW1 + 1)'(FIRST_DEPTH)) : PW1'(tsum1);
    tail2  = (tsum2 >= (CW2 + 1)'(SECOND_DEPTH)) ?
             PW2'(tsum2 - (CW2 + 1)'(SECOND_DEPTH)) : PW2'(tsum2);
    head1_inc = (first_head == PW1'(FIRST_DEPTH - 1)) ? '0 : first_head + 1'b1;
    head2_inc = (second_head == PW2'(SECOND_DEPTH - 1)) ? '0 : second_head + 1'b1;
  end

  always_comb begin
    stat.first_full     = (first_count == CW1'(FIRST_DEPTH));
    stat.second_full    = (second_count == CW2'(SECOND_DEPTH));
    stat.spill_more     = (second_count < CW2'(SECOND_DEPTH - 1)) && (first_count > CW1'(1));
    stat.first_empty    = (first_count == '0);
    stat.second_empty   = (second_count == '0);
    stat.first_at_last  = ((CW1 + 1)'(idx) + 1'b1) == (CW1 + 1)'(first_count);
    stat.second_at_last = ((CW2 + 1)'(idx) + 1'b1) == (CW2 + 1)'(second_count);
  end

  assign we1       = cmd.enq_push && !stat.first_full;
  assign rdata_sel = cmd.sel_second ? rdata2 : rdata1;

  tlsf_ram #(
    .WIDTH (REC_W),
    .DEPTH (FIRST_DEPTH)
  ) u_first_ram (
    .clk   (clk),
    .we    (we1),
    .waddr (tail1),
    .wdata (rec),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  tlsf_ram #(
    .WIDTH (REC_W),
    .DEPTH (SECOND_DEPTH)
  ) u_second_ram (
    .clk   (clk),
    .we    (cmd.spill_move),
    .waddr (tail2),
    .wdata (rdata1),
    .raddr (raddr2),
    .rdata (rdata2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_head   <= '0;
      first_count  <= '0;
      second_head  <= '0;
      second_count <= '0;
      idx          <= '0;
      moved        <= '0;
      valid        <= 1'b0;
    end else begin
      if (cmd.spill_move) begin
        first_head   <= head1_inc;
        first_count  <= first_count - 1'b1;
        second_count <= second_count + 1'b1;
      end
      if (we1) begin
        first_count <= first_count + 1'b1;
      end
      if (cmd.pop_first) begin
        first_head  <= head1_inc;
        first_count <= first_count - 1'b1;
      end
      if (cmd.pop_second) begin
        second_head  <= head2_inc;
        second_count <= second_count - 1'b1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.load_rec) begin
        moved <= '0;
      end else if (cmd.spill_move) begin
        moved <= moved + 1'b1;
      end
      valid <= cmd.emit_enq || cmd.emit_rec || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rec) begin
      rec <= {account, kind, amount_cents};
    end
    if (cmd.emit_enq) begin
      status      <= stat.first_full ? ST_REJECT : ST_OK;
      rec_account <= '0;
      rec_kind    <= 1'b0;
      rec_amount  <= '0;
      moved_count <= moved;
      last        <= 1'b1;
    end else if (cmd.emit_rec) begin
      status      <= ST_OK;
      rec_account <= rdata_sel[REC_W-1 -: ACCT_W];
      rec_kind    <= rdata_sel[AMT_W];
      rec_amount  <= rdata_sel[AMT_W-1:0];
      moved_count <= '0;
      last        <= cmd.last;
    end else if (cmd.emit_empty) begin
      status      <= ST_EMPTY;
      rec_account <= '0;
      rec_kind    <= 1'b0;
      rec_amount  <= '0;
      moved_count <= '0;
      last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: src/tlsf_ctrl.sv
`default_nettype none

module tlsf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [2:0]           opcode,
  input  wire tlsf_pkg::tlsf_stat_t stat,
  output logic                      busy,
  output tlsf_pkg::tlsf_cmd_t       cmd
);

  import tlsf_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SPILL_RD = 3'd1;
  localparam logic [2:0] S_SPILL_WR = 3'd2;
  localparam logic [2:0] S_ENQ      = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] op;
  logic       sel;
  logic       accept;
  logic       is_pop;
  logic       sel_empty;
  logic       at_last;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign is_pop    = (op == OP_POP1) || (op == OP_POP2);
  assign sel_empty = sel ? stat.second_empty : stat.first_empty;
  assign at_last   = sel ? stat.second_at_last : stat.first_at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ENQ;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op  <= opcode;
        sel <= (opcode == OP_POP2) || (opcode == OP_LIST2);
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_rec = 1'b1;
          case (opcode)
            OP_ENQ: begin
              state_next = (stat.first_full && !stat.second_full) ? S_SPILL_RD : S_ENQ;
            end
            OP_POP1, OP_POP2, OP_LIST1, OP_LIST2: begin
              state_next = S_EMIT;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SPILL_RD: begin
        state_next = S_SPILL_WR;
      end
      S_SPILL_WR: begin
        cmd.spill_move = 1'b1;
        state_next     = stat.spill_more ? S_SPILL_RD : S_ENQ;
      end
      S_ENQ: begin
        cmd.enq_push = 1'b1;
        cmd.emit_enq = 1'b1;
        state_next   = S_IDLE;
      end
      S_EMIT: begin
        cmd.sel_second = sel;
        cmd.look_ahead = 1'b1;
        if (sel_empty) begin
          cmd.emit_empty = 1'b1;
          cmd.idx_clr    = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.emit_rec = 1'b1;
          cmd.last     = is_pop || at_last;
          if (is_pop) begin
            cmd.pop_first  = !sel;
            cmd.pop_second = sel;
            cmd.idx_clr    = 1'b1;
            state_next     = S_IDLE;
          end else if (at_last) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/two_level_spill_fifo.sv
// two-level spill fifo: two circular queues of transaction records
// (account, kind, amount in cents); a full first queue spills its oldest
// records into the second queue on enqueue
// command channel: a command is taken at a clock edge with start high and
// busy low; opcode selects enqueue, pop first, pop second, list first or
// list second; codes 5 to 7 are taken and ignored
// result channel: each result sits on the result ports for one cycle with
// valid high; last marks the final result of a command
// result path: each result is registered from the controller state that
// makes it, S_ENQ for enqueue and S_EMIT for pop and list; enqueue first
// passes through S_SPILL_RD and S_SPILL_WR once for each record spilled;
// a list of n records walks the stored records and gives n results on
// back to back cycles, one ram read per cycle
// busy drops in the cycle the final result is shown, so the next command
// can be taken at the edge that ends it
// reset: both queues empty, no result pending; store contents are not cleared
// the receiver cannot stall: results are never held back
`default_nettype none

module two_level_spill_fifo #(
  parameter int FIRST_DEPTH  = tlsf_pkg::FIRST_DEPTH_DEF,
  parameter int SECOND_DEPTH = tlsf_pkg::SECOND_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [30:0] account,
  input  wire logic        kind,
  input  wire logic [31:0] amount_cents,
  output logic             valid,
  output logic [1:0]       status,
  output logic [30:0]      rec_account,
  output logic             rec_kind,
  output logic [31:0]      rec_amount,
  output logic [1:0]       moved_count,
  output logic             last
);

  import tlsf_pkg::*;

  tlsf_cmd_t  cmd;
  tlsf_stat_t stat;

  tlsf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  tlsf_dp #(
    .FIRST_DEPTH  (FIRST_DEPTH),
    .SECOND_DEPTH (SECOND_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .account      (account),
    .kind         (kind),
    .amount_cents (amount_cents),
    .valid        (valid),
    .status       (status),
    .rec_account  (rec_account),
    .rec_kind     (rec_kind),
    .rec_amount   (rec_amount),
    .moved_count  (moved_count),
    .last         (last)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
  import tlsf_pkg::*;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int Q1_DEPTH     = FIRST_DEPTH_DEF;
  localparam int Q2_DEPTH     = SECOND_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 320;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] account;
    logic        kind;
    logic [31:0] amount;
    logic [1:0]  moved;
    logic        last;
  } fifo_result_t;

  typedef struct {
    logic [2:0]   op;
    logic [30:0]  account;
    logic         kind;
    logic [31:0]  amount;
    bit           typed;
    fifo_result_t res;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  opcode = OP_ENQ;
  logic [30:0] account = '0;
  logic        kind = 1'b0;
  logic [31:0] amount_cents = '0;
  logic        busy;
  logic        valid;
  logic [1:0]  status;
  logic [30:0] rec_account;
  logic        rec_kind;
  logic [31:0] rec_amount;
  logic [1:0]  moved_count;
  logic        last;

  // predictor state
  logic [63:0] q1_store [Q1_DEPTH];
  logic [63:0] q2_store [Q2_DEPTH];
  int q1_head = 0;
  int q1_count = 0;
  int q2_head = 0;
  int q2_count = 0;

  fifo_result_t pending_results [$];
  fifo_result_t fresh_results [$];
  cmd_row_t     directed_rows [$];

  bit           typed_valid = 1'b0;
  fifo_result_t typed_result = '0;
  bit           steady = 1'b0;

  int mismatches = 0;
  int results_checked = 0;
  int spills = 0;
  int rejects = 0;
  int op_seen [8];

  two_level_spill_fifo dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .account(account),
    .kind(kind),
    .amount_cents(amount_cents),
    .valid(valid),
    .status(status),
    .rec_account(rec_account),
    .rec_kind(rec_kind),
    .rec_amount(rec_amount),
    .moved_count(moved_count),
    .last(last)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("two_level_spill_fifo regression: fail");
    $finish;
  end

  function automatic fifo_result_t record_result(input logic [63:0] rec, input logic is_last);
    return {ST_OK, rec, 2'd0, is_last};
  endfunction

  task automatic predict_fifo_results(input logic [2:0] op, input logic [30:0] acct,
                                      input logic k, input logic [31:0] amt);
    int moved;
    fifo_result_t r;
    fifo_result_t empty_res;
    empty_res = {ST_EMPTY, 64'd0, 2'd0, 1'b1};
    fresh_results.delete();
    case (op)
      OP_ENQ: begin
        moved = 0;
        if (q1_count == Q1_DEPTH) begin
          while (q2_count < Q2_DEPTH && q1_count > 0) begin
            q2_store[(q2_head + q2_count) % Q2_DEPTH] = q1_store[q1_head];
            q1_head = (q1_head + 1) % Q1_DEPTH;
            q1_count--;
            q2_count++;
            moved++;
          end
        end
        r = '0;
        r.moved = moved[1:0];
        r.last = 1'b1;
        if (q1_count < Q1_DEPTH) begin
          q1_store[(q1_head + q1_count) % Q1_DEPTH] = {acct, k, amt};
          q1_count++;
          r.status = ST_OK;
        end else begin
          r.status = ST_REJECT;
          rejects++;
        end
        if (moved > 0) spills++;
        fresh_results.push_back(r);
      end
      OP_POP1: begin
        if (q1_count == 0) begin
          fresh_results.push_back(empty_res);
        end else begin
          fresh_results.push_back(record_result(q1_store[q1_head], 1'b1));
          q1_head = (q1_head + 1) % Q1_DEPTH;
          q1_count--;
        end
      end
      OP_POP2: begin
        if (q2_count == 0) begin
          fresh_results.push_back(empty_res);
        end else begin
          fresh_results.push_back(record_result(q2_store[q2_head], 1'b1));
          q2_head = (q2_head + 1) % Q2_DEPTH;
          q2_count--;
        end
      end
      OP_LIST1: begin
        if (q1_count == 0) fresh_results.push_back(empty_res);
        for (int i = 0; i < q1_count; i++)
          fresh_results.push_back(record_result(q1_store[(q1_head + i) % Q1_DEPTH],
                                                i == q1_count - 1));
      end
      OP_LIST2: begin
        if (q2_count == 0) fresh_results.push_back(empty_res);
        for (int i = 0; i < q2_count; i++)
          fresh_results.push_back(record_result(q2_store[(q2_head + i) % Q2_DEPTH],
                                                i == q2_count - 1));
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : result_check
    fifo_result_t got;
    fifo_result_t want;
    if (!rst && valid) begin
      got = {status, rec_account, rec_kind, rec_amount, moved_count, last};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: status %0d account %h kind %0d amount %h %s %0d %s %0d",
                   got.status, got.account, got.kind, got.amount,
                   "moved", got.moved, "last", got.last);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch: expected status %0d account %h kind %0d amount %h %s %0d %s %0d",
                     want.status, want.account, want.kind, want.amount,
                     "moved", want.moved, "last", want.last);
            $display("          actual   status %0d account %h kind %0d amount %h %s %0d %s %0d",
                     got.status, got.account, got.kind, got.amount,
                     "moved", got.moved, "last", got.last);
          end
        end
      end
    end
    if (!rst && start && !busy) begin
      op_seen[opcode]++;
      predict_fifo_results(opcode, account, kind, amount_cents);
      if (typed_valid) begin
        pending_results.push_back(typed_result);
      end else begin
        foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
      end
    end
  end

  task automatic add_row(input logic [2:0] op, input logic [30:0] acct, input logic k,
                         input logic [31:0] amt, input bit typed, input logic [1:0] st,
                         input logic [1:0] moved);
    cmd_row_t row;
    row.op = op;
    row.account = acct;
    row.kind = k;
    row.amount = amt;
    row.typed = typed;
    row.res = {st, 64'd0, moved, 1'b1};
    directed_rows.push_back(row);
  endtask

  task automatic send_command(input logic [2:0] op, input logic [30:0] acct, input logic k,
                              input logic [31:0] amt, input bit use_typed,
                              input fifo_result_t typed_res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    account <= acct;
    kind <= k;
    amount_cents <= amt;
    typed_valid <= use_typed;
    typed_result <= typed_res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_pending();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int pick;
    bit fill_mode;
    logic [2:0] op;
    logic [30:0] acct;
    logic [31:0] amt;

    add_row(OP_POP1, '0, 1'b0, '0, 1'b1, ST_EMPTY, 2'd0);
    add_row(OP_POP2, '0, 1'b0, '0, 1'b1, ST_EMPTY, 2'd0);
    add_row(OP_LIST1, '0, 1'b0, '0, 1'b1, ST_EMPTY, 2'd0);
    add_row(OP_LIST2, '0, 1'b0, '0, 1'b1, ST_EMPTY, 2'd0);
    add_row(OP_SPARE5, '1, 1'b1, '1, 1'b0, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'h7fffffff, 1'b1, 32'hffffffff, 1'b1, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'd0, 1'b0, 32'd0, 1'b1, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'h2aaaaaaa, 1'b0, 32'h55555555, 1'b1, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'h55555555, 1'b1, 32'haaaaaaaa, 1'b1, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'd1, 1'b0, 32'd1, 1'b1, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'h40000000, 1'b1, 32'h80000000, 1'b1, ST_OK, 2'd0);
    add_row(OP_LIST1, '0, 1'b0, '0, 1'b0, ST_OK, 2'd0);
    // first queue full, second empty: three records spill
    add_row(OP_ENQ, 31'd77, 1'b0, 32'd12345, 1'b1, ST_OK, 2'd3);
    add_row(OP_LIST2, '0, 1'b0, '0, 1'b0, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'h12345678, 1'b1, 32'hdeadbeef, 1'b0, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'h0badcafe, 1'b0, 32'h00c0ffee, 1'b0, ST_OK, 2'd0);
    // both queues full: rejected, nothing moves
    add_row(OP_ENQ, 31'd999, 1'b1, 32'd999, 1'b1, ST_REJECT, 2'd0);
    add_row(OP_SPARE6, '1, 1'b1, '1, 1'b0, ST_OK, 2'd0);
    add_row(OP_POP2, '0, 1'b0, '0, 1'b0, ST_OK, 2'd0);
    add_row(OP_POP1, '0, 1'b0, '0, 1'b0, ST_OK, 2'd0);
    add_row(OP_LIST1, '0, 1'b0, '0, 1'b0, ST_OK, 2'd0);
    add_row(OP_LIST2, '0, 1'b0, '0, 1'b0, ST_OK, 2'd0);
    add_row(OP_SPARE7, '1, 1'b1, '1, 1'b0, ST_OK, 2'd0);
    add_row(OP_ENQ, 31'd4242, 1'b1, 32'd100, 1'b0, ST_OK, 2'd0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_command(directed_rows[i].op, directed_rows[i].account, directed_rows[i].kind,
                   directed_rows[i].amount, directed_rows[i].typed, directed_rows[i].res);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 80 == 40) drain_pending();
      fill_mode = ((sent / 40) % 2) == 0;
      steady = ((sent / 30) % 3) == 2;
      pick = $urandom_range(0, 99);
      if (pick < 5) op = 3'($urandom_range(OP_SPARE7, OP_SPARE5));
      else if (pick < (fill_mode ? 55 : 30)) op = OP_ENQ;
      else if (pick < (fill_mode ? 65 : 55)) op = OP_POP1;
      else if (pick < 75) op = OP_POP2;
      else if (pick < 87) op = OP_LIST1;
      else op = OP_LIST2;
      acct = 31'($urandom);
      amt = $urandom;
      send_command(op, acct, 1'($urandom_range(0, 1)), amt, 1'b0, '0);
      if (op <= OP_LIST2) sent++;
    end

    drain_pending();
    repeat (12) @(posedge clk);

    $display("ran %0d enqueue, %0d pop, %0d list and %0d unused-code transactions",
             op_seen[OP_ENQ], op_seen[OP_POP1] + op_seen[OP_POP2],
             op_seen[OP_LIST1] + op_seen[OP_LIST2],
             op_seen[OP_SPARE5] + op_seen[OP_SPARE6] + op_seen[OP_SPARE7]);
    $display("%0d results checked, %0d enqueues spilled, %0d rejected, %0d mismatches",
             results_checked, spills, rejects, mismatches);
    if (mismatches == 0) begin
      $display("two_level_spill_fifo regression: pass");
    end else begin
      $display("two_level_spill_fifo regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
